FILE: src/cft_pkg.sv
// cft_pkg: types, constants and helper functions for the csv field tokenizer
// used by cft_step, cft_res_queue and csv_field_tokenizer_unit; no dependencies
`default_nettype none
package cft_pkg;

	localparam int ROW_W = 24;
	localparam int COL_W = 12;
	localparam int LEN_W = 12;

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
	localparam logic [LEN_W-1:0] FIELD_LIMIT_RESET = LEN_W'(255);

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam logic OP_DATA = 1'b0;
	localparam logic OP_EOI  = 1'b1;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_FEND  = 2'd1;
	localparam logic [1:0] KIND_REND  = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	typedef enum logic [1:0] {
		ST_BETWEEN = 2'd0,
		ST_QUOTED  = 2'd1,
		ST_QCHECK  = 2'd2,
		ST_FIELD   = 2'd3
	} parse_state_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       field_char;
		logic [ROW_W-1:0] row_number;
		logic [COL_W-1:0] column_number;
		logic [LEN_W-1:0] field_length;
		logic             last;
	} out_item_t;

	typedef struct packed {
		logic [1:0] count;
		out_item_t  r0;
		out_item_t  r1;
	} step_res_t;

	function automatic logic is_blank(input logic [7:0] c);
		is_blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C)
			|| (c == 8'h0D);
	endfunction

endpackage
`default_nettype wire

FILE: src/cft_step.sv
// cft_step: next parser state and up to two result beats for one input beat
// depends on cft_pkg
`default_nettype none
module cft_step (
	input  wire cft_pkg::parse_state_t    st,
	input  wire logic [cft_pkg::ROW_W-1:0] row,
	input  wire logic [cft_pkg::COL_W-1:0] col,
	input  wire logic [cft_pkg::LEN_W-1:0] len,
	input  wire logic [cft_pkg::LEN_W-1:0] limit,
	input  wire cft_pkg::in_item_t        item,
	output cft_pkg::parse_state_t         st_nxt,
	output logic [cft_pkg::ROW_W-1:0]     row_nxt,
	output logic [cft_pkg::COL_W-1:0]     col_nxt,
	output logic [cft_pkg::LEN_W-1:0]     len_nxt,
	output cft_pkg::step_res_t            res
);

	logic [cft_pkg::LEN_W-1:0] lim;
	logic                      room;
	logic                      room0;
	logic [7:0]                ch;
	logic                      is_q;
	logic                      is_c;
	logic                      is_lf;
	logic                      is_bl;

	assign lim   = (limit < cft_pkg::LEN_MAX) ? limit : cft_pkg::LEN_MAX;
	assign room  = len < lim;
	assign room0 = lim != '0;
	assign ch    = item.data_byte;
	assign is_q  = ch == cft_pkg::CH_QUOTE;
	assign is_c  = ch == cft_pkg::CH_COMMA;
	assign is_lf = ch == cft_pkg::CH_LF;
	assign is_bl = cft_pkg::is_blank(ch);

	function automatic cft_pkg::out_item_t mk(input logic [1:0] k, input logic [7:0] c,
			input logic [cft_pkg::LEN_W-1:0] l, input logic lst);
		cft_pkg::out_item_t r;
		r.kind          = k;
		r.field_char    = c;
		r.row_number    = row;
		r.column_number = col;
		r.field_length  = l;
		r.last          = lst;
		mk = r;
	endfunction

	// next state
	always_comb begin
		st_nxt  = st;
		row_nxt = row;
		col_nxt = col;
		len_nxt = len;
		if (item.operation == cft_pkg::OP_EOI) begin
			if (st != cft_pkg::ST_QUOTED && st != cft_pkg::ST_BETWEEN) begin
				st_nxt = cft_pkg::ST_BETWEEN;
			end
		end else begin
			case (st)
				cft_pkg::ST_BETWEEN: begin
					if (is_q) begin
						st_nxt  = cft_pkg::ST_QUOTED;
						len_nxt = '0;
					end else if (is_c) begin
						col_nxt = col + 1'b1;
					end else if (is_lf) begin
						row_nxt = row + 1'b1;
						col_nxt = '0;
					end else if (!is_bl) begin
						st_nxt  = cft_pkg::ST_FIELD;
						len_nxt = room0 ? cft_pkg::LEN_W'(1) : '0;
					end
				end
				cft_pkg::ST_QUOTED: begin
					if (is_q) begin
						st_nxt = cft_pkg::ST_QCHECK;
					end else if (room) begin
						len_nxt = len + 1'b1;
					end
				end
				cft_pkg::ST_QCHECK: begin
					if (is_q) begin
						st_nxt = cft_pkg::ST_QUOTED;
						if (room) begin
							len_nxt = len + 1'b1;
						end
					end else if (is_c) begin
						st_nxt  = cft_pkg::ST_BETWEEN;
						col_nxt = col + 1'b1;
					end else if (is_lf) begin
						st_nxt  = cft_pkg::ST_BETWEEN;
						row_nxt = row + 1'b1;
						col_nxt = '0;
					end
				end
				default: begin
					if (is_c) begin
						st_nxt  = cft_pkg::ST_BETWEEN;
						col_nxt = col + 1'b1;
					end else if (is_lf) begin
						st_nxt  = cft_pkg::ST_BETWEEN;
						row_nxt = row + 1'b1;
						col_nxt = '0;
					end else if (ch != cft_pkg::CH_CR && room) begin
						len_nxt = len + 1'b1;
					end
				end
			endcase
		end
	end

	// result beats
	always_comb begin
		res.count = 2'd0;
		res.r0    = mk(cft_pkg::KIND_BYTE, 8'h00, '0, 1'b1);
		res.r1    = mk(cft_pkg::KIND_REND, 8'h00, '0, 1'b1);
		if (item.operation == cft_pkg::OP_EOI) begin
			if (st == cft_pkg::ST_QUOTED) begin
				res.count = 2'd1;
				res.r0    = mk(cft_pkg::KIND_ERROR, 8'h00, len, 1'b1);
			end else if (st != cft_pkg::ST_BETWEEN) begin
				res.count = 2'd2;
				res.r0    = mk(cft_pkg::KIND_FEND, 8'h00, len, 1'b0);
			end
		end else begin
			case (st)
				cft_pkg::ST_BETWEEN: begin
					if (is_lf) begin
						res.count = 2'd1;
						res.r0    = mk(cft_pkg::KIND_REND, 8'h00, '0, 1'b1);
					end else if (!is_q && !is_c && !is_bl && room0) begin
						res.count = 2'd1;
						res.r0    = mk(cft_pkg::KIND_BYTE, ch, '0, 1'b1);
					end
				end
				cft_pkg::ST_QUOTED: begin
					if (!is_q && room) begin
						res.count = 2'd1;
						res.r0    = mk(cft_pkg::KIND_BYTE, ch, len, 1'b1);
					end
				end
				cft_pkg::ST_QCHECK: begin
					if (is_q) begin
						if (room) begin
							res.count = 2'd1;
							res.r0    = mk(cft_pkg::KIND_BYTE, ch, len, 1'b1);
						end
					end else if (is_c) begin
						res.count = 2'd1;
						res.r0    = mk(cft_pkg::KIND_FEND, 8'h00, len, 1'b1);
					end else if (is_lf) begin
						res.count = 2'd2;
						res.r0    = mk(cft_pkg::KIND_FEND, 8'h00, len, 1'b0);
					end else if (!is_bl) begin
						res.count = 2'd1;
						res.r0    = mk(cft_pkg::KIND_ERROR, 8'h00, len, 1'b1);
					end
				end
				default: begin
					if (is_c) begin
						res.count = 2'd1;
						res.r0    = mk(cft_pkg::KIND_FEND, 8'h00, len, 1'b1);
					end else if (is_lf) begin
						res.count = 2'd2;
						res.r0    = mk(cft_pkg::KIND_FEND, 8'h00, len, 1'b0);
					end else if (ch != cft_pkg::CH_CR && room) begin
						res.count = 2'd1;
						res.r0    = mk(cft_pkg::KIND_BYTE, ch, len, 1'b1);
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: src/cft_res_queue.sv
// cft_res_queue: small queue of per-item result pairs, drained one beat a cycle while out_ready is high
// depends on cft_pkg
`default_nettype none
module cft_res_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire cft_pkg::step_res_t push_res,
	output logic                    full,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output cft_pkg::out_item_t      out_data
);

	cft_pkg::out_item_t           r0_q [cft_pkg::Q_DEPTH];
	cft_pkg::out_item_t           r1_q [cft_pkg::Q_DEPTH];
	logic [cft_pkg::Q_CNT_W-1:0]  count_q;
	logic [cft_pkg::Q_PTR_W-1:0]  wr_q;
	logic [cft_pkg::Q_PTR_W-1:0]  rd_q;
	logic                         sel_q;
	logic                         beat;
	logic                         pop;

	assign full      = count_q == cft_pkg::Q_CNT_W'(cft_pkg::Q_DEPTH);
	assign out_valid = count_q != '0;
	assign out_data  = sel_q ? r1_q[rd_q] : r0_q[rd_q];
	assign beat      = out_valid && out_ready;
	assign pop       = beat && out_data.last;

	always_ff @(posedge clk) begin
		if (push) begin
			r0_q[wr_q] <= push_res.r0;
			r1_q[wr_q] <= push_res.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wr_q    <= '0;
			rd_q    <= '0;
			sel_q   <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (beat) begin
				sel_q <= !out_data.last;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: src/csv_field_tokenizer_unit.sv
// csv_field_tokenizer_unit: top level of the byte-serial csv field tokenizer
// depends on cft_pkg, cft_step and cft_res_queue
//
// usage:
//   in channel (in_valid/in_ready/in_data) takes one beat per cycle while
//   in_ready is high: a data byte or an end-of-input mark. the parser state,
//   row, column and field length counters update at the accepting edge.
//   each input beat causes zero, one or two result beats on the out channel
//   (out_valid/out_ready/out_data); last marks the final beat of an item.
//   results are registered into the queue at the edge that takes the input.
//   throughput: one input beat per cycle while each item gives at most one
//   result and out_ready is high; a two-result item holds out for both beats.
//   results wait in a two-entry queue of result pairs; in_ready drops only
//   when that queue is full, so a stalled receiver backs up the input.
//   cfg_wr_en/cfg_wr_data write field_limit at the clock edge, no read-back.
//   reset: parser between fields, counters zero, field_limit 255, queue empty.
`default_nettype none
module csv_field_tokenizer_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [cft_pkg::LEN_W-1:0] cfg_wr_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire cft_pkg::in_item_t         in_data,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output cft_pkg::out_item_t             out_data
);

	cft_pkg::parse_state_t       st_q;
	logic [cft_pkg::ROW_W-1:0]   row_q;
	logic [cft_pkg::COL_W-1:0]   col_q;
	logic [cft_pkg::LEN_W-1:0]   len_q;
	logic [cft_pkg::LEN_W-1:0]   field_limit_q;

	cft_pkg::parse_state_t       st_nxt;
	logic [cft_pkg::ROW_W-1:0]   row_nxt;
	logic [cft_pkg::COL_W-1:0]   col_nxt;
	logic [cft_pkg::LEN_W-1:0]   len_nxt;
	cft_pkg::step_res_t          res;
	logic                        q_full;
	logic                        accept;
	logic                        push;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (res.count != 2'd0);

	cft_step u_step (
		.st      (st_q),
		.row     (row_q),
		.col     (col_q),
		.len     (len_q),
		.limit   (field_limit_q),
		.item    (in_data),
		.st_nxt  (st_nxt),
		.row_nxt (row_nxt),
		.col_nxt (col_nxt),
		.len_nxt (len_nxt),
		.res     (res)
	);

	cft_res_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (res),
		.full      (q_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= cft_pkg::ST_BETWEEN;
			row_q         <= '0;
			col_q         <= '0;
			len_q         <= '0;
			field_limit_q <= cft_pkg::FIELD_LIMIT_RESET;
		end else begin
			if (cfg_wr_en) begin
				field_limit_q <= cfg_wr_data;
			end
			if (accept) begin
				st_q  <= st_nxt;
				row_q <= row_nxt;
				col_q <= col_nxt;
				len_q <= len_nxt;
			end
		end
	end

endmodule
`default_nettype wire
